/* design/fsp_pkg.sv */
package fsp_pkg;

    // Field widths
    localparam int ANGLE_W = 11;
    localparam int SINE_W  = 18;

    // Cycles from an accepted start to its done strobe
    localparam int LATENCY = 9;

    // Folded angle, 16.16 fraction of a turn in -1/4..+1/4
    typedef logic signed [15:0] fold_t;
    // Square of the folded angle, 0..4096
    typedef logic [12:0] sq_t;
    // Horner accumulator
    typedef logic signed [23:0] poly_t;
    // Odd-polynomial result before clamping
    typedef logic signed [18:0] wide_t;
    typedef logic signed [SINE_W-1:0] sine_t;

    // Payload carried through the Horner stages
    typedef struct packed {
        fold_t x;
        sq_t   s;
        poly_t r;
    } hn_t;

    // 720ths of a turn to a 16.16 fraction of a turn
    localparam logic [22:0] TURN_SCALE = 23'd5965232;

    // Fold thresholds on the fraction of a turn
    localparam logic [15:0] FRAC_QUARTER  = 16'd16384;
    localparam logic [15:0] FRAC_HALF     = 16'd32768;
    localparam logic [15:0] FRAC_3QUARTER = 16'd49152;

    // Polynomial coefficients, leading one first
    localparam poly_t POLY_TOP = 24'sd2602479;
    localparam int    N_STEPS  = 4;
    localparam poly_t POLY_COEF [N_STEPS] = '{
        -24'sd5018418,
         24'sd5347884,
        -24'sd2709368,
         24'sd411775
    };

    // Saturation limits, plus and minus one in 16.16
    localparam wide_t ONE_POS = 19'sd65536;
    localparam wide_t ONE_NEG = -19'sd65536;

endpackage

/* design/fsp_fold.sv */
module fsp_fold (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [fsp_pkg::ANGLE_W-1:0]      angle,
    output logic                             out_valid,
    output fsp_pkg::fold_t                   x
);

    logic [33:0]          scaled;
    logic [15:0]          frac_reg;
    logic [15:0]          frac_next;
    logic                 v1_reg;
    fsp_pkg::fold_t       x_reg;
    fsp_pkg::fold_t       x_next;
    logic                 v2_reg;

    // Stage 1: scale to a fraction of a turn, keep the fractional bits
    assign scaled    = {23'd0, angle} * {11'd0, fsp_pkg::TURN_SCALE};
    assign frac_next = scaled[31:16];

    // Stage 2: fold into a quarter turn either side of zero
    always_comb
    begin
        if (frac_reg > fsp_pkg::FRAC_3QUARTER)
        begin
            // frac - 1.0, same low bits read as signed
            x_next = fsp_pkg::fold_t'(frac_reg);
        end
        else if (frac_reg > fsp_pkg::FRAC_QUARTER)
        begin
            x_next = fsp_pkg::fold_t'(fsp_pkg::FRAC_HALF - frac_reg);
        end
        else
        begin
            x_next = fsp_pkg::fold_t'(frac_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
        x_reg    <= x_next;
    end

    assign out_valid = v2_reg;
    assign x         = x_reg;

endmodule

/* design/fsp_square.sv */
module fsp_square (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fsp_pkg::fold_t     x,
    output logic               out_valid,
    output fsp_pkg::hn_t       beat
);

    logic signed [31:0] sq_full;
    fsp_pkg::hn_t       beat_reg;
    fsp_pkg::hn_t       beat_next;
    logic               v_reg;

    // Square of the folded angle; never negative, at most 4096 after the shift
    assign sq_full = x * x;

    always_comb
    begin
        beat_next.x = x;
        beat_next.s = sq_full[28:16];
        beat_next.r = fsp_pkg::POLY_TOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = v_reg;
    assign beat      = beat_reg;

endmodule

/* design/fsp_horner_step.sv */
module fsp_horner_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fsp_pkg::hn_t       in_beat,
    input  fsp_pkg::poly_t     coef,
    output logic               out_valid,
    output fsp_pkg::hn_t       out_beat
);

    logic signed [37:0] prod;
    logic signed [37:0] prod_sh;
    fsp_pkg::hn_t       beat_reg;
    fsp_pkg::hn_t       beat_next;
    logic               v_reg;

    // r = coef + floor(s * r / 2^16)
    assign prod    = $signed({1'b0, in_beat.s}) * in_beat.r;
    assign prod_sh = prod >>> 16;

    always_comb
    begin
        beat_next   = in_beat;
        beat_next.r = coef + prod_sh[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = v_reg;
    assign out_beat  = beat_reg;

endmodule

/* design/fsp_odd_sat.sv */
module fsp_odd_sat (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fsp_pkg::hn_t       in_beat,
    output logic               out_valid,
    output fsp_pkg::sine_t     sine
);

    logic signed [39:0] y_full;
    logic signed [39:0] y_sh;
    fsp_pkg::wide_t     y_reg;
    logic               v1_reg;
    fsp_pkg::sine_t     sine_reg;
    fsp_pkg::sine_t     sine_next;
    logic               v2_reg;

    // Stage 1: final multiply by the folded angle
    assign y_full = in_beat.x * in_beat.r;
    assign y_sh   = y_full >>> 16;

    // Stage 2: clamp to plus or minus one
    always_comb
    begin
        if (y_reg > fsp_pkg::ONE_POS)
        begin
            sine_next = fsp_pkg::ONE_POS[fsp_pkg::SINE_W-1:0];
        end
        else if (y_reg < fsp_pkg::ONE_NEG)
        begin
            sine_next = fsp_pkg::ONE_NEG[fsp_pkg::SINE_W-1:0];
        end
        else
        begin
            sine_next = y_reg[fsp_pkg::SINE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_sh[18:0];
        sine_reg <= sine_next;
    end

    assign out_valid = v2_reg;
    assign sine      = sine_reg;

endmodule

/* design/fixed_point_sine_polynomial.sv */
// Channel   Ports                 Beat taken when
// -------   -------------------   ---------------------------
// command   start, busy, angle    start high and busy low
// result    done, sine            done high (one cycle only)
//
// One angle can be started in every cycle; busy stays low.
// Each result passes through one stage each for the turn scaling multiply,
// the fold, the square, four Horner multiply-adds, the final multiply and
// the clamp. Results leave in start order.
// Reset clears the stage valid bits only; the receiver cannot stall.
module fixed_point_sine_polynomial (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fsp_pkg::ANGLE_W-1:0]       angle,
    output logic                              done,
    output logic signed [fsp_pkg::SINE_W-1:0] sine
);

    logic            accept;
    logic            fold_valid;
    fsp_pkg::fold_t  fold_x;
    logic            hn_valid [fsp_pkg::N_STEPS+1];
    fsp_pkg::hn_t    hn_beat  [fsp_pkg::N_STEPS+1];

    // Pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Scale and fold
    fsp_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (angle),
        .out_valid (fold_valid),
        .x         (fold_x)
    );

    // Square of the folded angle
    fsp_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .x         (fold_x),
        .out_valid (hn_valid[0]),
        .beat      (hn_beat[0])
    );

    // Horner chain, one coefficient per stage
    for (genvar g = 0; g < fsp_pkg::N_STEPS; g++)
    begin : g_horner
        fsp_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (hn_valid[g]),
            .in_beat   (hn_beat[g]),
            .coef      (fsp_pkg::POLY_COEF[g]),
            .out_valid (hn_valid[g+1]),
            .out_beat  (hn_beat[g+1])
        );
    end

    // Final multiply and clamp
    fsp_odd_sat u_odd_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hn_valid[fsp_pkg::N_STEPS]),
        .in_beat   (hn_beat[fsp_pkg::N_STEPS]),
        .out_valid (done),
        .sine      (sine)
    );

`ifndef SYNTHESIS
    // Every result traces back to a start exactly one latency earlier
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, fsp_pkg::LATENCY))
        else $error("done without a matching start");

    // Clamp keeps the result within plus or minus one
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sine <= 18'sd65536 && sine >= -18'sd65536))
        else $error("sine out of range");

    // Angle zero must give exactly zero
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept && angle == '0, fsp_pkg::LATENCY)) |-> sine == '0)
        else $error("nonzero sine for zero angle");

    // Folded angle stays within a quarter turn either side of zero
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        fold_valid |-> (fold_x <= 16'sd16384 && fold_x >= -16'sd16384))
        else $error("fold out of range");
`endif

endmodule

/* dv/fsp_checker.sv */
module fsp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [fsp_pkg::ANGLE_W-1:0]       angle,
    input  logic                              done,
    input  logic signed [fsp_pkg::SINE_W-1:0] sine,
    output int                                fail_count,
    output int                                sines_owed
);

    // Fixed-point constants of the sine datapath
    localparam longint ANGLE_TO_TURN = 64'sd5965232;
    localparam longint TURN_FRAC     = 64'sd65535;
    localparam longint FX_ONE        = 64'sd65536;
    localparam longint FX_HALF       = 64'sd32768;
    localparam longint FX_QUARTER    = 64'sd16384;
    localparam longint FX_3QUARTER   = 64'sd49152;
    localparam longint LEAD_COEF     = 64'sd2602479;
    localparam int     HORNER_STEPS  = 4;

    fsp_pkg::sine_t sine_q[$];

    // Signed 16.16 product, arithmetic shift rounds toward minus infinity
    function automatic longint fx_mult(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint horner_coef(input int idx);
        case (idx)
            0:       return -64'sd5018418;
            1:       return 64'sd5347884;
            2:       return -64'sd2709368;
            default: return 64'sd411775;
        endcase
    endfunction

    // Expected sine for one angle
    function automatic fsp_pkg::sine_t predict_sine(input logic [fsp_pkg::ANGLE_W-1:0] ang);
        longint frac;
        longint sq;
        longint acc;
        longint y;
        frac = fx_mult(longint'(ang), ANGLE_TO_TURN) & TURN_FRAC;
        // fold into -1/4..+1/4 turn
        if (frac > FX_3QUARTER)
            frac = frac - FX_ONE;
        else if (frac > FX_QUARTER)
            frac = FX_HALF - frac;
        sq  = fx_mult(frac, frac);
        acc = LEAD_COEF;
        for (int i = 0; i < HORNER_STEPS; i++)
        begin
            acc = horner_coef(i) + fx_mult(sq, acc);
        end
        y = fx_mult(frac, acc);
        // clamp overshoot to plus or minus one
        if (y > FX_ONE)
            y = FX_ONE;
        if (y < -FX_ONE)
            y = -FX_ONE;
        return fsp_pkg::sine_t'(y);
    endfunction

    // Predict on each command beat, compare on each result beat
    always @(posedge clk or negedge rst_n)
    begin
        fsp_pkg::sine_t exp_sine;
        if (!rst_n)
        begin
            sine_q.delete();
            fail_count <= 0;
            sines_owed <= 0;
        end
        else
        begin
            if (start === 1'b1 && busy === 1'b0)
                sine_q.push_back(predict_sine(angle));
            if (done === 1'b1)
            begin
                if (sine_q.size() == 0)
                begin
                    $error("result beat with no angle outstanding, sine %0d", sine);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_sine = sine_q.pop_front();
                    if (sine !== exp_sine)
                    begin
                        $error("sine mismatch: expected %0d, actual %0d", exp_sine, sine);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            sines_owed <= sine_q.size();
        end
    end

endmodule

/* dv/tb.sv */
module tb;

    localparam int N_RANDOM    = 950;
    localparam int CYCLE_LIMIT = 40000;
    localparam int TURN        = 720;

    typedef logic [fsp_pkg::ANGLE_W-1:0] angle_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    angle_t               angle;
    logic                 done;
    fsp_pkg::sine_t       sine;
    int                   fail_count;
    int                   sines_owed;
    int                   cycles = 0;

    // 8-unit clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    fixed_point_sine_polynomial i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .angle (angle),
        .done  (done),
        .sine  (sine)
    );

    fsp_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .angle      (angle),
        .done       (done),
        .sine       (sine),
        .fail_count (fail_count),
        .sines_owed (sines_owed)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One command beat; start stays high into the next beat unless a gap follows
    task automatic send_angle(input angle_t ang);
        start <= 1'b1;
        angle <= ang;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic gap_cycle();
        start <= 1'b0;
        angle <= angle_t'($urandom);
        @(posedge clk);
    endtask

    // Random angle, a quarter of them near the fold points
    function automatic angle_t pick_angle();
        int base;
        if ($urandom_range(3) == 0)
        begin
            base = 180 * $urandom_range(11);
            return angle_t'(base + $urandom_range(4) - 2 + (base == 0 ? 2 : 0));
        end
        return angle_t'($urandom);
    endfunction

    initial
    begin
        angle_t directed[$];
        rst_n  = 1'b0;
        start  = 1'b0;
        angle  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, quarter-turn folds, full-turn wrap, near-peak overshoot
        directed = '{
            11'd0, 11'd2047, 11'd1, 11'd90, 11'd179, 11'd180, 11'd181,
            11'd270, 11'd359, 11'd360, 11'd361, 11'd539, 11'd540, 11'd541,
            11'd719, 11'd720, 11'd721, 11'd900, 11'd1080, 11'd1440,
            11'd1620, 11'd1979, 11'd1980, 11'd2046, 11'd1024
        };
        foreach (directed[i])
        begin
            if (i % 5 == 4)
                gap_cycle();
            send_angle(directed[i]);
        end

        // random angles; a back-to-back stretch in the middle
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if ((n < 400 || n >= 600) && $urandom_range(99) < 22)
            begin
                repeat ($urandom_range(3, 1))
                    gap_cycle();
            end
            send_angle(pick_angle());
        end
        start <= 1'b0;

        // drain outstanding results
        @(posedge clk);
        while (sines_owed != 0)
            @(posedge clk);
        repeat (fsp_pkg::LATENCY + 4) @(posedge clk);

        if (fail_count == 0 && sines_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
